FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the incidence angle block.
// Depends on nothing; included by the checker with a bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only while the block is out of reset.
`define SIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("incidence angle check failed");

// Next-cycle implication that is also checked during reset.
`define SIA_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("incidence angle check failed");

`endif

FILE: src/sia_pkg.sv
// Package for the solar incidence angle unit: widths, fixed-point constants,
// the arctangent table and the pipeline latency. Depends on nothing.
package sia_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int NLANE             = 4;
  localparam int ANG_W             = 16;
  localparam int TILT_W            = 15;
  localparam int OUT_W             = 15;
  localparam int XY_W              = 20;
  localparam int Z_W               = 34;
  localparam int PROD_W            = 2 * XY_W;
  localparam int DOT_W             = 18;
  localparam int ROOT_W            = 34;
  localparam int ROOT_STEPS        = 17;
  localparam int FIXED_STAGES      = 30;

  localparam int FULL_CDEG    = 36000;
  localparam int HALF_CDEG    = 18000;
  localparam int QUART_CDEG   = 9000;
  localparam int TILT_RESET   = 3700;
  localparam int AZ_RESET     = 18000;

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint GAIN_Q16    = 64'd39797;
  localparam longint ONE_Q16     = 64'd65536;

  // Lane order inside the trigonometry pipeline.
  localparam int LANE_TILT  = 0;
  localparam int LANE_SAZ   = 1;
  localparam int LANE_ZEN   = 2;
  localparam int LANE_SUNAZ = 3;

  typedef enum logic [0:0] {
    REG_TILT    = 1'b0,
    REG_AZIMUTH = 1'b1
  } cfg_reg_t;

  typedef logic signed [XY_W-1:0]   xy_t;
  typedef logic signed [Z_W-1:0]    ang_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [DOT_W-1:0]  dot_t;

  function automatic ang_t atan_q30(input int i);
    ang_t v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048576;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      24: v = 34'sd64;
      25: v = 34'sd32;
      26: v = 34'sd16;
      27: v = 34'sd8;
      28: v = 34'sd4;
      29: v = 34'sd2;
      30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Product of two Q3.16 values rounded back to Q3.16.
  function automatic xy_t round_q16(input prod_t p);
    prod_t t;
    t = (p + prod_t'(32768)) >>> 16;
    return t[XY_W-1:0];
  endfunction

  function automatic int pipe_latency(input int n);
    return 2 * n + FIXED_STAGES;
  endfunction

endpackage

FILE: src/solar_incidence_angle_unit.sv
// Top level of the solar incidence angle unit: a fully pipelined CORDIC
// datapath. Depends on sia_pkg.
//
// The unit takes one transaction per clock cycle: a pair of sun zenith and
// azimuth angles in hundredths of a degree, accepted whenever start is high
// (busy is always low, since nothing in the pipeline ever waits). Each
// transaction produces exactly one result, the angle between the sun
// direction and the surface normal, on out_incidence_cdeg for one cycle
// with out_valid high. The pipeline is the angle reduction and scaling, the
// rotation CORDIC, the dot product stages, the seventeen-step square root,
// the vectoring CORDIC for the arccosine and the conversion back to
// centidegrees. The receiver cannot stall the output, so results must be
// taken as they appear. Surface tilt and azimuth are written through the
// cfg_ port and must only change while no transaction is in flight.
module solar_incidence_angle_unit #(
  parameter int CORDIC_STAGES = sia_pkg::CORDIC_STAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [sia_pkg::TILT_W-1:0]  in_sun_zenith_cdeg,
  input  logic [sia_pkg::ANG_W-1:0]   in_sun_azimuth_cdeg,
  output logic                        out_valid,
  output logic [sia_pkg::OUT_W-1:0]   out_incidence_cdeg,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sia_pkg::ANG_W-1:0]   cfg_data
);
  import sia_pkg::*;

  localparam int LAT = pipe_latency(CORDIC_STAGES);

  // Split of pi/18000 into quotient and remainder so that the scaling of a
  // centidegree angle to radians needs only narrow products.
  localparam longint DIV_Q      = PI_Q30 / HALF_CDEG;
  localparam longint DIV_R      = PI_Q30 % HALF_CDEG;
  localparam longint RECIP_18K  = ((64'd1 << 40) + HALF_CDEG - 1) / HALF_CDEG;
  localparam longint RECIP_PI   = (64'(HALF_CDEG) << 48) / PI_Q30;

  // Configuration registers.
  logic [TILT_W-1:0] tilt_r;
  logic [ANG_W-1:0]  saz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tilt_r <= TILT_W'(TILT_RESET);
      saz_r  <= ANG_W'(AZ_RESET);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TILT:    tilt_r <= cfg_data[TILT_W-1:0];
        REG_AZIMUTH: saz_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so every start is a transaction.
  assign busy = 1'b0;

  logic [LAT-1:0] valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[LAT-2:0], start & ~busy};
    end
  end

  // Stage A: reduce each angle to -90..90 degrees with a flip flag.
  logic [ANG_W-1:0]  raw_w [NLANE];
  logic [ANG_W-1:0]  a1_w  [NLANE];
  logic signed [16:0] a2_w [NLANE];
  logic signed [16:0] m_w  [NLANE];
  logic signed [16:0] mabs_w [NLANE];
  logic              flip_w [NLANE];

  assign raw_w[LANE_TILT]  = {1'b0, tilt_r};
  assign raw_w[LANE_SAZ]   = saz_r;
  assign raw_w[LANE_ZEN]   = {1'b0, in_sun_zenith_cdeg};
  assign raw_w[LANE_SUNAZ] = in_sun_azimuth_cdeg;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      a1_w[l] = (raw_w[l] >= ANG_W'(FULL_CDEG)) ? raw_w[l] - ANG_W'(FULL_CDEG) : raw_w[l];
      a2_w[l] = (a1_w[l] > ANG_W'(HALF_CDEG)) ?
                $signed({1'b0, a1_w[l]}) - $signed(17'(FULL_CDEG)) :
                $signed({1'b0, a1_w[l]});
      if (a2_w[l] > $signed(17'(QUART_CDEG))) begin
        m_w[l]    = a2_w[l] - $signed(17'(HALF_CDEG));
        flip_w[l] = 1'b1;
      end else if (a2_w[l] < -$signed(17'(QUART_CDEG))) begin
        m_w[l]    = a2_w[l] + $signed(17'(HALF_CDEG));
        flip_w[l] = 1'b1;
      end else begin
        m_w[l]    = a2_w[l];
        flip_w[l] = 1'b0;
      end
      mabs_w[l] = m_w[l][16] ? -m_w[l] : m_w[l];
    end
  end

  logic [13:0] a_mag_r  [NLANE];
  logic        a_neg_r  [NLANE];
  logic        a_flip_r [NLANE];
  logic [31:0] b_p_r    [NLANE];
  logic [25:0] b_n_r    [NLANE];
  logic        b_neg_r  [NLANE];
  logic        b_flip_r [NLANE];
  logic [31:0] c_p_r    [NLANE];
  logic [11:0] c_q_r    [NLANE];
  logic        c_neg_r  [NLANE];
  logic        c_flip_r [NLANE];

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANE; l++) begin
      a_mag_r[l]  <= mabs_w[l][13:0];
      a_neg_r[l]  <= m_w[l][16];
      a_flip_r[l] <= flip_w[l];
      // Stage B: integer and fractional parts of mag * pi / 18000.
      b_p_r[l]    <= 32'(64'(a_mag_r[l]) * 64'(DIV_Q));
      b_n_r[l]    <= 26'(64'(a_mag_r[l]) * 64'(DIV_R) + 64'(QUART_CDEG));
      b_neg_r[l]  <= a_neg_r[l];
      b_flip_r[l] <= a_flip_r[l];
      // Stage C: the fractional part divided by 18000 through a reciprocal.
      c_p_r[l]    <= b_p_r[l];
      c_q_r[l]    <= 12'((64'(b_n_r[l]) * 64'(RECIP_18K)) >> 40);
      c_neg_r[l]  <= b_neg_r[l];
      c_flip_r[l] <= b_flip_r[l];
    end
  end

  // Rotation CORDIC, one iteration per stage; index 0 is the start vector.
  xy_t  rot_x_r    [CORDIC_STAGES+1][NLANE];
  xy_t  rot_y_r    [CORDIC_STAGES+1][NLANE];
  ang_t rot_z_r    [CORDIC_STAGES+1][NLANE];
  logic rot_flip_r [CORDIC_STAGES+1][NLANE];

  ang_t zmag_w [NLANE];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      zmag_w[l] = ang_t'(c_p_r[l]) + ang_t'(c_q_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NLANE; l++) begin
      rot_x_r[0][l]    <= xy_t'(GAIN_Q16);
      rot_y_r[0][l]    <= '0;
      rot_z_r[0][l]    <= c_neg_r[l] ? -zmag_w[l] : zmag_w[l];
      rot_flip_r[0][l] <= c_flip_r[l];
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    always_ff @(posedge clk) begin
      for (int l = 0; l < NLANE; l++) begin
        if (!rot_z_r[k][l][Z_W-1]) begin
          rot_x_r[k+1][l] <= rot_x_r[k][l] - (rot_y_r[k][l] >>> k);
          rot_y_r[k+1][l] <= rot_y_r[k][l] + (rot_x_r[k][l] >>> k);
          rot_z_r[k+1][l] <= rot_z_r[k][l] - atan_q30(k);
        end else begin
          rot_x_r[k+1][l] <= rot_x_r[k][l] + (rot_y_r[k][l] >>> k);
          rot_y_r[k+1][l] <= rot_y_r[k][l] - (rot_x_r[k][l] >>> k);
          rot_z_r[k+1][l] <= rot_z_r[k][l] + atan_q30(k);
        end
        rot_flip_r[k+1][l] <= rot_flip_r[k][l];
      end
    end
  end

  // Sines and cosines after the quadrant flip.
  xy_t sin_w [NLANE];
  xy_t cos_w [NLANE];
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      sin_w[l] = rot_flip_r[CORDIC_STAGES][l] ? -rot_y_r[CORDIC_STAGES][l] :
                 rot_y_r[CORDIC_STAGES][l];
      cos_w[l] = rot_flip_r[CORDIC_STAGES][l] ? -rot_x_r[CORDIC_STAGES][l] :
                 rot_x_r[CORDIC_STAGES][l];
    end
  end

  // Stage E: raw products for the horizontal vector components.
  prod_t e_nx_r, e_ny_r, e_vx_r, e_vy_r;
  xy_t   e_nz_r, e_vz_r;
  // Stage F: rounded unit vectors.
  xy_t   f_nx_r, f_ny_r, f_vx_r, f_vy_r, f_nz_r, f_vz_r;
  // Stage G: component products of the dot product.
  prod_t g_x_r, g_y_r, g_z_r;
  // Stage H: rounded and saturated cosine of the incidence angle.
  dot_t  h_c_r;
  logic signed [41:0] dsum_w;
  logic signed [41:0] dround_w;
  dot_t  dsat_w;

  always_comb begin
    dsum_w   = 42'(g_x_r) + 42'(g_y_r) + 42'(g_z_r);
    dround_w = (dsum_w + 42'sd32768) >>> 16;
    if (dround_w > 42'(ONE_Q16)) begin
      dsat_w = dot_t'(ONE_Q16);
    end else if (dround_w < -42'(ONE_Q16)) begin
      dsat_w = -dot_t'(ONE_Q16);
    end else begin
      dsat_w = dround_w[DOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    e_nx_r <= prod_t'(sin_w[LANE_TILT]) * prod_t'(cos_w[LANE_SAZ]);
    e_ny_r <= prod_t'(sin_w[LANE_TILT]) * prod_t'(sin_w[LANE_SAZ]);
    e_vx_r <= prod_t'(sin_w[LANE_ZEN]) * prod_t'(cos_w[LANE_SUNAZ]);
    e_vy_r <= prod_t'(sin_w[LANE_ZEN]) * prod_t'(sin_w[LANE_SUNAZ]);
    e_nz_r <= cos_w[LANE_TILT];
    e_vz_r <= cos_w[LANE_ZEN];
    f_nx_r <= round_q16(e_nx_r);
    f_ny_r <= round_q16(e_ny_r);
    f_vx_r <= round_q16(e_vx_r);
    f_vy_r <= round_q16(e_vy_r);
    f_nz_r <= e_nz_r;
    f_vz_r <= e_vz_r;
    g_x_r  <= prod_t'(f_nx_r) * prod_t'(f_vx_r);
    g_y_r  <= prod_t'(f_ny_r) * prod_t'(f_vy_r);
    g_z_r  <= prod_t'(f_nz_r) * prod_t'(f_vz_r);
    h_c_r  <= dsat_w;
  end

  // Stage I and the square root: s = floor(sqrt(2^32 - c*c)), one result
  // bit per stage, starting from the bit of weight 2^16.
  logic signed [35:0] csq_w;
  assign csq_w = 36'(h_c_r) * 36'(h_c_r);

  logic [ROOT_W-1:0] sq_v_r [ROOT_STEPS+1];
  logic [ROOT_W-1:0] sq_r_r [ROOT_STEPS+1];
  dot_t              sq_c_r [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    sq_v_r[0] <= ROOT_W'(36'sd4294967296 - csq_w);
    sq_r_r[0] <= '0;
    sq_c_r[0] <= h_c_r;
  end

  for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (ROOT_STEPS - 1 - j));
    logic [ROOT_W-1:0] trial_w;
    assign trial_w = sq_r_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (sq_v_r[j] >= trial_w) begin
        sq_v_r[j+1] <= sq_v_r[j] - trial_w;
        sq_r_r[j+1] <= (sq_r_r[j] >> 1) + BIT;
      end else begin
        sq_v_r[j+1] <= sq_v_r[j];
        sq_r_r[j+1] <= sq_r_r[j] >> 1;
      end
      sq_c_r[j+1] <= sq_c_r[j];
    end
  end

  // Vectoring CORDIC for the arccosine; a negative cosine is first turned
  // by a quarter turn so the vector starts in the right half plane.
  xy_t  vec_x_r [CORDIC_STAGES+1];
  xy_t  vec_y_r [CORDIC_STAGES+1];
  ang_t vec_z_r [CORDIC_STAGES+1];
  xy_t  root_w;
  xy_t  cos_c_w;

  assign root_w  = xy_t'(sq_r_r[ROOT_STEPS][ROOT_STEPS-1:0]);
  assign cos_c_w = xy_t'(sq_c_r[ROOT_STEPS]);

  always_ff @(posedge clk) begin
    if (!cos_c_w[XY_W-1]) begin
      vec_x_r[0] <= cos_c_w;
      vec_y_r[0] <= root_w;
      vec_z_r[0] <= '0;
    end else begin
      vec_x_r[0] <= root_w;
      vec_y_r[0] <= -cos_c_w;
      vec_z_r[0] <= ang_t'(HALF_PI_Q30);
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
    always_ff @(posedge clk) begin
      if (!vec_y_r[k][XY_W-1]) begin
        vec_x_r[k+1] <= vec_x_r[k] + (vec_y_r[k] >>> k);
        vec_y_r[k+1] <= vec_y_r[k] - (vec_x_r[k] >>> k);
        vec_z_r[k+1] <= vec_z_r[k] + atan_q30(k);
      end else begin
        vec_x_r[k+1] <= vec_x_r[k] - (vec_y_r[k] >>> k);
        vec_y_r[k+1] <= vec_y_r[k] + (vec_x_r[k] >>> k);
        vec_z_r[k+1] <= vec_z_r[k] - atan_q30(k);
      end
    end
  end

  // Stages K to M: radians to centidegrees. A reciprocal estimate of the
  // quotient sits at most two below the true one; the remainder decides.
  logic [31:0]  zclamp_w;
  logic [31:0]  k_z_r;
  logic [14:0]  k_q_r;
  logic [14:0]  l_q_r;
  logic [47:0]  l_num_r;
  logic [47:0]  l_qpi_r;
  logic [47:0]  rem_w;
  logic [15:0]  quot_w;
  logic [OUT_W-1:0] m_out_r;

  assign zclamp_w = vec_z_r[CORDIC_STAGES][Z_W-1] ? '0 : vec_z_r[CORDIC_STAGES][31:0];

  always_comb begin
    rem_w  = l_num_r - l_qpi_r;
    quot_w = 16'(l_q_r) + 16'(rem_w >= 48'(PI_Q30)) + 16'(rem_w >= 48'(2 * PI_Q30));
  end

  always_ff @(posedge clk) begin
    k_z_r   <= zclamp_w;
    k_q_r   <= 15'((64'(zclamp_w) * 64'(RECIP_PI)) >> 48);
    l_q_r   <= k_q_r;
    l_qpi_r <= 48'(64'(k_q_r) * 64'(PI_Q30));
    l_num_r <= 48'(64'(k_z_r) * 64'(HALF_CDEG) + 64'(HALF_PI_Q30));
    m_out_r <= (quot_w > 16'(HALF_CDEG)) ? OUT_W'(HALF_CDEG) : quot_w[OUT_W-1:0];
  end

  assign out_valid          = valid_r[LAT-1];
  assign out_incidence_cdeg = m_out_r;

endmodule

FILE: src/sia_checker.sv
// Port-level checker for the solar incidence angle unit and its bind.
// Depends on sia_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sia_checker #(
  parameter int CORDIC_STAGES = sia_pkg::CORDIC_STAGES_DEF
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [sia_pkg::OUT_W-1:0] out_incidence_cdeg
);
  import sia_pkg::*;

  localparam int LAT = pipe_latency(CORDIC_STAGES);

  // Every result stays within the half turn.
  `SIA_ASSERT_IMP(a_out_range, clk, rst_n, out_valid, out_incidence_cdeg <= OUT_W'(HALF_CDEG))
  // A result only ever follows a transaction by the fixed latency.
  `SIA_ASSERT_IMP(a_latency, clk, rst_n, out_valid, $past(start && !busy, LAT))
  // The pipeline never holds off the sender.
  `SIA_ASSERT_IMP(a_never_busy, clk, rst_n, 1'b1, !busy)
  // Reset flushes every transaction in flight.
  `SIA_ASSERT_NXT(a_reset_flush, clk, !rst_n, !out_valid)

endmodule

bind solar_incidence_angle_unit sia_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_sia_checker (.*);
